[rtl/i2cmb_pkg.sv]
// Package for the I2C target double-buffered mailbox.
// Sizes, function and result codes, payload and controller/datapath structs.
// No dependencies.
package i2cmb_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int BW = $clog2(MAX_FRAME_BYTES);
  localparam int AW = BW + 1;
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int STORE_DEPTH = 2 << BW;

  localparam logic [1:0] FUNC_EVENT   = 2'd0;
  localparam logic [1:0] FUNC_PUBLISH = 2'd1;
  localparam logic [1:0] FUNC_POLL    = 2'd2;

  localparam logic [1:0] KIND_BUS   = 2'd0;
  localparam logic [1:0] KIND_PUB   = 2'd1;
  localparam logic [1:0] KIND_POLL  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic       ev_rx_full;
    logic       ev_rd_req;
    logic       ev_stop;
    logic       ev_abort;
    logic       ev_rx_over;
    logic [7:0] data_byte;
    logic [5:0] pub_index;
    logic       pub_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        ok;
    logic [7:0]  out_byte;
    logic        last;
    logic [15:0] dropped_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_single;
    logic poll_rd;
    logic load_poll;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       poll_stream;
    logic       poll_last;
    logic       out_free;
  } sts_t;

endpackage

[rtl/i2cmb_in_if.sv]
// Input channel of the mailbox: valid/ready handshake with an in_item_t payload.
// Depends on i2cmb_pkg.
interface i2cmb_in_if;
  logic                valid;
  logic                ready;
  i2cmb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/i2cmb_out_if.sv]
// Result channel of the mailbox: valid/ready handshake with an out_item_t payload.
// Depends on i2cmb_pkg.
interface i2cmb_out_if;
  logic                 valid;
  logic                 ready;
  i2cmb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/i2cmb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/i2cmb_ctrl.sv]
// Controller state machine of the mailbox: sequences accept, execute, respond
// and the poll stream. Depends on i2cmb_pkg.
module i2cmb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cmb_pkg::sts_t sts,
  output i2cmb_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_RESP  = 5'b00100,
    ST_PRD   = 5'b01000,
    ST_PEMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.func == i2cmb_pkg::FUNC_EVENT || sts.func == i2cmb_pkg::FUNC_PUBLISH) begin
          state_next = ST_RESP;
        end else if (sts.func == i2cmb_pkg::FUNC_POLL) begin
          state_next = sts.poll_stream ? ST_PRD : ST_RESP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_single = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PRD: begin
        cmd.poll_rd = 1'b1;
        state_next = ST_PEMIT;
      end
      ST_PEMIT: begin
        if (sts.out_free) begin
          cmd.load_poll = 1'b1;
          state_next = sts.poll_last ? ST_IDLE : ST_PRD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/i2cmb_dp.sv]
// Datapath of the mailbox: receive and transmit stores, buffer lengths and
// selects, drop counter and result register. Depends on i2cmb_pkg, i2cmb_ram.
module i2cmb_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  i2cmb_pkg::cmd_t       cmd,
  output i2cmb_pkg::sts_t       sts,
  input  i2cmb_pkg::in_item_t   in_data,
  output logic                  out_valid,
  output i2cmb_pkg::out_item_t  out_data,
  input  logic                  out_ready
);

  localparam int LW = i2cmb_pkg::LW;
  localparam int BW = i2cmb_pkg::BW;
  localparam int AW = i2cmb_pkg::AW;
  localparam logic [LW-1:0] MAXLEN = LW'(i2cmb_pkg::MAX_FRAME_BYTES);

  i2cmb_pkg::in_item_t item;

  logic [LW-1:0] rx_len [2];
  logic [LW-1:0] rx_len_next [2];
  logic          rx_write_sel, rx_write_sel_next;
  logic          rx_ready_sel, rx_ready_sel_next;
  logic          rx_ready_flag, rx_ready_flag_next;
  logic [LW-1:0] tx_len [2];
  logic [LW-1:0] tx_len_next [2];
  logic          tx_active_sel, tx_active_sel_next;
  logic [LW-1:0] tx_read_pos, tx_read_pos_next;
  logic [15:0]   drop_counter, drop_counter_next;
  logic [1:0]    drop_inc;

  logic          rsp_txv, rsp_txv_next;
  logic          rsp_hit, rsp_hit_next;
  logic          rsp_ok, rsp_ok_next;

  logic          poll_sel;
  logic [BW-1:0] poll_pos;
  logic [LW-1:0] poll_len;

  logic          rx_we;
  logic [AW-1:0] rx_waddr;
  logic [7:0]    rx_rdata;
  logic          tx_we;
  logic [AW-1:0] tx_waddr;
  logic          tx_re;
  logic [AW-1:0] tx_raddr;
  logic [7:0]    tx_rdata;
  logic          w_sel, a_sel, inact;
  logic [LW-1:0] lenw;

  i2cmb_ram #(.WIDTH(8), .DEPTH(i2cmb_pkg::STORE_DEPTH)) u_rx_store (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (item.data_byte),
    .re    (cmd.poll_rd),
    .raddr ({poll_sel, poll_pos}),
    .rdata (rx_rdata)
  );

  i2cmb_ram #(.WIDTH(8), .DEPTH(i2cmb_pkg::STORE_DEPTH)) u_tx_store (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (item.data_byte),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  assign w_sel = rx_write_sel;
  assign a_sel = tx_active_sel;
  assign inact = ~tx_active_sel;

  always_comb begin
    rx_len_next        = rx_len;
    rx_write_sel_next  = rx_write_sel;
    rx_ready_sel_next  = rx_ready_sel;
    rx_ready_flag_next = rx_ready_flag;
    tx_len_next        = tx_len;
    tx_active_sel_next = tx_active_sel;
    tx_read_pos_next   = tx_read_pos;
    drop_inc           = 2'd0;
    rsp_txv_next       = 1'b0;
    rsp_hit_next       = 1'b0;
    rsp_ok_next        = 1'b0;
    rx_we              = 1'b0;
    rx_waddr           = {w_sel, rx_len[w_sel][BW-1:0]};
    tx_we              = 1'b0;
    tx_waddr           = {inact, item.pub_index[BW-1:0]};
    tx_re              = 1'b0;
    tx_raddr           = {a_sel, tx_read_pos[BW-1:0]};
    lenw               = rx_len[w_sel];
    if (cmd.exec) begin
      case (item.func)
        i2cmb_pkg::FUNC_EVENT: begin
          if (item.ev_rx_full) begin
            if (rx_len[w_sel] < MAXLEN) begin
              rx_we = 1'b1;
              lenw = rx_len[w_sel] + LW'(1);
              rx_len_next[w_sel] = lenw;
            end else begin
              drop_inc = drop_inc + 2'd1;
            end
          end
          if (item.ev_rd_req) begin
            rsp_txv_next = 1'b1;
            if (tx_read_pos < tx_len[a_sel]) begin
              tx_re = 1'b1;
              rsp_hit_next = 1'b1;
              tx_read_pos_next = tx_read_pos + LW'(1);
            end
          end
          if (item.ev_stop) begin
            if (lenw != '0) begin
              if (rx_ready_flag) begin
                rx_len_next[w_sel] = '0;
                drop_inc = drop_inc + 2'd1;
              end else begin
                rx_ready_sel_next  = w_sel;
                rx_ready_flag_next = 1'b1;
                rx_write_sel_next  = ~w_sel;
                rx_len_next[~w_sel] = '0;
              end
            end
            tx_read_pos_next = '0;
          end
          if (item.ev_abort) begin
            tx_read_pos_next = '0;
          end
          if (item.ev_rx_over) begin
            drop_inc = drop_inc + 2'd1;
          end
        end
        i2cmb_pkg::FUNC_PUBLISH: begin
          if (int'(item.pub_index) < i2cmb_pkg::MAX_FRAME_BYTES) begin
            tx_we = 1'b1;
            if (!item.pub_last) begin
              rsp_ok_next = 1'b1;
            end else if (tx_read_pos == '0) begin
              tx_len_next[inact] = LW'(item.pub_index) + LW'(1);
              tx_active_sel_next = inact;
              rsp_ok_next = 1'b1;
            end
          end
        end
        i2cmb_pkg::FUNC_POLL: begin
          if (rx_ready_flag) begin
            rx_len_next[rx_ready_sel] = '0;
            rx_ready_flag_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    drop_counter_next = drop_counter + 16'(drop_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_len        <= '{default: '0};
      rx_write_sel  <= 1'b0;
      rx_ready_sel  <= 1'b0;
      rx_ready_flag <= 1'b0;
      tx_len        <= '{default: '0};
      tx_active_sel <= 1'b0;
      tx_read_pos   <= '0;
      drop_counter  <= '0;
    end else begin
      rx_len        <= rx_len_next;
      rx_write_sel  <= rx_write_sel_next;
      rx_ready_sel  <= rx_ready_sel_next;
      rx_ready_flag <= rx_ready_flag_next;
      tx_len        <= tx_len_next;
      tx_active_sel <= tx_active_sel_next;
      tx_read_pos   <= tx_read_pos_next;
      drop_counter  <= drop_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.exec) begin
      rsp_txv  <= rsp_txv_next;
      rsp_hit  <= rsp_hit_next;
      rsp_ok   <= rsp_ok_next;
      poll_sel <= rx_ready_sel;
      poll_len <= rx_len[rx_ready_sel];
      poll_pos <= '0;
    end else if (cmd.load_poll) begin
      poll_pos <= poll_pos + BW'(1);
    end
  end

  assign sts.func        = item.func;
  assign sts.poll_stream = rx_ready_flag && (rx_len[rx_ready_sel] != '0);
  assign sts.poll_last   = (LW'(poll_pos) + LW'(1) == poll_len);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_poll) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_data.out_byte      <= 8'd0;
      out_data.last          <= 1'b1;
      out_data.dropped_count <= drop_counter;
      case (item.func)
        i2cmb_pkg::FUNC_EVENT: begin
          out_data.kind     <= i2cmb_pkg::KIND_BUS;
          out_data.tx_valid <= rsp_txv;
          out_data.tx_byte  <= rsp_hit ? tx_rdata : 8'd0;
          out_data.ok       <= 1'b0;
        end
        i2cmb_pkg::FUNC_PUBLISH: begin
          out_data.kind     <= i2cmb_pkg::KIND_PUB;
          out_data.tx_valid <= 1'b0;
          out_data.tx_byte  <= 8'd0;
          out_data.ok       <= rsp_ok;
        end
        default: begin
          out_data.kind     <= i2cmb_pkg::KIND_EMPTY;
          out_data.tx_valid <= 1'b0;
          out_data.tx_byte  <= 8'd0;
          out_data.ok       <= 1'b0;
        end
      endcase
    end else if (cmd.load_poll) begin
      out_data.kind          <= i2cmb_pkg::KIND_POLL;
      out_data.tx_valid      <= 1'b0;
      out_data.tx_byte       <= 8'd0;
      out_data.ok            <= 1'b1;
      out_data.out_byte      <= rx_rdata;
      out_data.last          <= sts.poll_last;
      out_data.dropped_count <= drop_counter;
    end
  end

`ifndef SYNTHESIS
  a_rx_len_bound: assert property (@(posedge clk) disable iff (rst)
    rx_len[0] <= MAXLEN && rx_len[1] <= MAXLEN)
    else $error("receive length beyond frame size");
  a_tx_pos_bound: assert property (@(posedge clk) disable iff (rst)
    tx_read_pos <= tx_len[tx_active_sel] || tx_read_pos == '0)
    else $error("transmit read position past buffer length");
  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    rx_ready_flag |-> rx_len[rx_ready_sel] != '0)
    else $error("ready frame is empty");
  a_ready_apart: assert property (@(posedge clk) disable iff (rst)
    rx_ready_flag |-> rx_write_sel != rx_ready_sel)
    else $error("write buffer overlaps ready frame");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_single || cmd.load_poll) |-> (!out_valid || out_ready))
    else $error("result register overwritten before transaction");
`endif

endmodule

[rtl/i2c_target_double_buffer_mailbox.sv]
// Double-buffered mailbox for an I2C target: bus events, transmit publish and
// receive frame poll. A bus event or a publish passes the execute and respond
// states and then loads its one result into the output register; a poll of a
// ready frame passes the execute state and then, for each byte, a registered
// read of the receive store and an emit state, which paces the bytes. Each
// load waits while the output register holds a result not yet taken. The
// block takes a new transaction once the last result of the previous one is
// in the output register, and not before. Depends on i2cmb_pkg, i2cmb_in_if,
// i2cmb_out_if, i2cmb_ctrl, i2cmb_dp.
module i2c_target_double_buffer_mailbox (
  input  logic        clk,
  input  logic        rst,
  i2cmb_in_if.sink    item,
  i2cmb_out_if.source result
);

  i2cmb_pkg::cmd_t cmd;
  i2cmb_pkg::sts_t sts;

  i2cmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2cmb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (item.data),
    .out_valid (result.valid),
    .out_data  (result.data),
    .out_ready (result.ready)
  );

endmodule

[test/tb_i2c_target_double_buffer_mailbox.sv]
`timescale 1ns / 100ps
// Self-checking testbench for i2c_target_double_buffer_mailbox: directed and random
// transactions under several idle/stall phases, every result checked against a predictor.
// Depends on i2cmb_pkg, i2cmb_in_if, i2cmb_out_if and the mailbox RTL.
module tb_i2c_target_double_buffer_mailbox;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 16;

  logic clk;
  logic rst;

  i2cmb_in_if  item_ch ();
  i2cmb_out_if result_ch ();

  i2c_target_double_buffer_mailbox dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // predicted mailbox state
  logic [7:0]              rx_mem [0:i2cmb_pkg::STORE_DEPTH-1];
  logic [i2cmb_pkg::LW-1:0] rx_fill [2];
  logic                    rx_wsel;
  logic                    rx_rsel;
  logic                    rx_ready;
  logic [7:0]              tx_mem [0:i2cmb_pkg::STORE_DEPTH-1];
  bit                      tx_written [0:i2cmb_pkg::STORE_DEPTH-1];
  logic [i2cmb_pkg::LW-1:0] tx_fill [2];
  logic                    tx_sel;
  logic [i2cmb_pkg::LW-1:0] tx_pos;
  logic [15:0]             drops;

  i2cmb_pkg::out_item_t pending_replies [$];
  i2cmb_pkg::out_item_t want;
  i2cmb_pkg::out_item_t got;

  int send_idle_pct;
  int stall_pct;
  int items_sent;
  int results_seen;
  int frame_bytes_seen;
  int errors;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  function automatic void predict_replies(i2cmb_pkg::in_item_t it);
    i2cmb_pkg::out_item_t r;
    int                   w;
    int                   n;
    int                   i;
    r = '0;
    r.last = 1'b1;
    case (it.func)
      i2cmb_pkg::FUNC_EVENT: begin
        r.kind = i2cmb_pkg::KIND_BUS;
        if (it.ev_rx_full) begin
          w = int'(rx_wsel);
          if (rx_fill[w] < i2cmb_pkg::MAX_FRAME_BYTES) begin
            rx_mem[w * i2cmb_pkg::MAX_FRAME_BYTES + rx_fill[w]] = it.data_byte;
            rx_fill[w]++;
          end else begin
            drops++;
          end
        end
        if (it.ev_rd_req) begin
          w = int'(tx_sel);
          r.tx_valid = 1'b1;
          if (tx_pos < tx_fill[w]) begin
            r.tx_byte = tx_mem[w * i2cmb_pkg::MAX_FRAME_BYTES + tx_pos];
            tx_pos++;
          end
        end
        if (it.ev_stop) begin
          w = int'(rx_wsel);
          if (rx_fill[w] != 0) begin
            if (rx_ready) begin
              rx_fill[w] = '0;
              drops++;
            end else begin
              rx_rsel = 1'(w);
              rx_ready = 1'b1;
              rx_wsel = !w;
              rx_fill[!w] = '0;
            end
          end
          tx_pos = '0;
        end
        if (it.ev_abort) tx_pos = '0;
        if (it.ev_rx_over) drops++;
        r.dropped_count = drops;
        pending_replies.push_back(r);
      end
      i2cmb_pkg::FUNC_PUBLISH: begin
        r.kind = i2cmb_pkg::KIND_PUB;
        w = int'(!tx_sel);
        tx_mem[w * i2cmb_pkg::MAX_FRAME_BYTES + it.pub_index] = it.data_byte;
        tx_written[w * i2cmb_pkg::MAX_FRAME_BYTES + it.pub_index] = 1'b1;
        if (!it.pub_last) begin
          r.ok = 1'b1;
        end else if (tx_pos == 0) begin
          tx_fill[w] = i2cmb_pkg::LW'(it.pub_index) + i2cmb_pkg::LW'(1);
          tx_sel = 1'(w);
          r.ok = 1'b1;
        end
        r.dropped_count = drops;
        pending_replies.push_back(r);
      end
      i2cmb_pkg::FUNC_POLL: begin
        r.dropped_count = drops;
        r.kind = i2cmb_pkg::KIND_EMPTY;
        if (rx_ready) begin
          w = int'(rx_rsel);
          n = int'(rx_fill[w]);
          rx_fill[w] = '0;
          rx_ready = 1'b0;
          for (i = 0; i < n; i++) begin
            r.kind = i2cmb_pkg::KIND_POLL;
            r.ok = 1'b1;
            r.out_byte = rx_mem[w * i2cmb_pkg::MAX_FRAME_BYTES + i];
            r.last = (i == n - 1);
            pending_replies.push_back(r);
          end
        end
        if (n == 0 || !r.ok) pending_replies.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic i2cmb_pkg::in_item_t mk_event(bit rx, bit rd, bit stp, bit abt, bit ovr,
                                                   logic [7:0] d);
    i2cmb_pkg::in_item_t it;
    it = i2cmb_pkg::in_item_t'({$urandom, $urandom});
    it.func = i2cmb_pkg::FUNC_EVENT;
    it.ev_rx_full = rx;
    it.ev_rd_req = rd;
    it.ev_stop = stp;
    it.ev_abort = abt;
    it.ev_rx_over = ovr;
    it.data_byte = d;
    return it;
  endfunction

  function automatic i2cmb_pkg::in_item_t mk_publish(logic [7:0] d, logic [5:0] idx, bit lst);
    i2cmb_pkg::in_item_t it;
    it = i2cmb_pkg::in_item_t'({$urandom, $urandom});
    it.func = i2cmb_pkg::FUNC_PUBLISH;
    it.data_byte = d;
    it.pub_index = idx;
    it.pub_last = lst;
    return it;
  endfunction

  function automatic i2cmb_pkg::in_item_t mk_poll();
    i2cmb_pkg::in_item_t it;
    it = i2cmb_pkg::in_item_t'({$urandom, $urandom});
    it.func = i2cmb_pkg::FUNC_POLL;
    return it;
  endfunction

  // never read a transmit entry that was not published
  task automatic send_item(i2cmb_pkg::in_item_t it);
    if (it.func == i2cmb_pkg::FUNC_EVENT && it.ev_rd_req && tx_pos < tx_fill[tx_sel] &&
        !tx_written[{tx_sel, tx_pos[i2cmb_pkg::BW-1:0]}])
      it.ev_rd_req = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_replies(it);
    items_sent++;
  endtask

  task automatic hold_off();
    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(mk_poll());
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'hff));
    send_item(mk_publish(8'hff, 6'd0, 1'b0));
    send_item(mk_publish(8'h00, 6'd63, 1'b0));
    send_item(mk_publish(8'h5a, 6'd1, 1'b1));
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    // final publish refused mid-read
    send_item(mk_publish(8'h33, 6'd0, 1'b1));
    send_item(mk_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hff));
    send_item(mk_event(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h80));
    send_item(mk_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    // all five flags together
    send_item(mk_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h7e));
    send_item(mk_poll());
    send_item(mk_poll());
    send_item(mk_publish(8'h01, 6'd0, 1'b1));
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
  endtask

  task automatic test_rx_overflow();
    int i;
    send_idle_pct = 7;
    stall_pct = 7;
    hold_off();
    for (i = 0; i < i2cmb_pkg::MAX_FRAME_BYTES + 2; i++)
      send_item(mk_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'($urandom)));
    send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom)));
    send_item(mk_poll());
  endtask

  task automatic test_mixed_traffic(int n, int idle_pct, int stall);
    int target;
    int pick;
    int len;
    int i;
    i2cmb_pkg::in_item_t it;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if ($urandom_range(29) == 0) hold_off();
      if (pick < 25) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 6);
        for (i = 0; i < len; i++)
          send_item(mk_event(1'b1, $urandom_range(15) == 0,
                             (i == len - 1) && $urandom_range(1),
                             1'b0, $urandom_range(19) == 0, 8'($urandom)));
        if ($urandom_range(7) != 0)
          send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom)));
      end else if (pick < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 8);
        for (i = 0; i < len; i++)
          send_item(mk_event($urandom_range(9) == 0, 1'b1, 1'b0, 1'b0, 1'b0,
                             8'($urandom)));
        case ($urandom_range(7))
          6: send_item(mk_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'($urandom)));
          7: ;
          default: send_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'($urandom)));
        endcase
      end else if (pick < 65) begin
        len = ($urandom_range(7) == 0) ? i2cmb_pkg::MAX_FRAME_BYTES : $urandom_range(1, 8);
        for (i = 0; i < len - 1; i++)
          send_item(mk_publish(8'($urandom), 6'(i), 1'b0));
        if ($urandom_range(7) == 0)
          send_item(mk_publish(8'($urandom), 6'($urandom_range(63)), 1'b1));
        else
          send_item(mk_publish(8'($urandom), 6'(len - 1), 1'b1));
      end else if (pick < 80) begin
        send_item(mk_poll());
      end else begin
        it = i2cmb_pkg::in_item_t'({$urandom, $urandom});
        it.func = 2'($urandom_range(2));
        send_item(it);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        results_seen++;
        if (got.kind == i2cmb_pkg::KIND_POLL) frame_bytes_seen++;
        if (pending_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind %0d txv %0d txb %h ok %0d ob %h last %0d drops %0d",
                     got.kind, got.tx_valid, got.tx_byte, got.ok, got.out_byte,
                     got.last, got.dropped_count);
        end else begin
          want = pending_replies.pop_front();
          if (got.kind !== want.kind || got.tx_valid !== want.tx_valid ||
              got.tx_byte !== want.tx_byte || got.ok !== want.ok ||
              got.out_byte !== want.out_byte || got.last !== want.last ||
              got.dropped_count !== want.dropped_count) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at result %0d", results_seen);
              $display("  exp: kind %0d txv %0d txb %h ok %0d ob %h last %0d drops %0d",
                       want.kind, want.tx_valid, want.tx_byte, want.ok, want.out_byte,
                       want.last, want.dropped_count);
              $display("  got: kind %0d txv %0d txb %h ok %0d ob %h last %0d drops %0d",
                       got.kind, got.tx_valid, got.tx_byte, got.ok, got.out_byte,
                       got.last, got.dropped_count);
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (rst !== 1'b0 || quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    results_seen = 0;
    frame_bytes_seen = 0;
    errors = 0;
    quiet_cycles = 0;
    rx_fill = '{'0, '0};
    tx_fill = '{'0, '0};
    rx_wsel = 1'b0;
    rx_rsel = 1'b0;
    rx_ready = 1'b0;
    tx_sel = 1'b0;
    tx_pos = '0;
    drops = '0;
    foreach (tx_written[i]) tx_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_rx_overflow();
    test_mixed_traffic(70, 0, 0);
    test_mixed_traffic(70, 86, 0);
    test_mixed_traffic(70, 0, 86);
    test_mixed_traffic(70, 7, 7);
    test_mixed_traffic(10, 0, 0);

    item_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions; checked %0d results, %0d of them received-frame bytes",
             items_sent, results_seen, frame_bytes_seen);
    $display("Final drop count %0d, %0d mismatches", drops, errors);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/i2cmb_pkg.sv
rtl/i2cmb_in_if.sv
rtl/i2cmb_out_if.sv
rtl/i2cmb_ram.sv
rtl/i2cmb_ctrl.sv
rtl/i2cmb_dp.sv
rtl/i2c_target_double_buffer_mailbox.sv
test/tb_i2c_target_double_buffer_mailbox.sv
